// ===== hdl/rhc_pkg.sv =====
// ----------------------------------------------------------------------------
// rhc_pkg: shared constants and types for the rgb to hsv converter
// channel and hue widths, fixed-point constants and the word carried
// down the divider pipeline
// ----------------------------------------------------------------------------
package rhc_pkg;

  localparam int CHANNEL_BITS  = 8;
  localparam int HUE_FRAC_BITS = 6;

  // hue spans 0 .. 360 degrees, so 9 integer bits
  localparam int HUE_BITS      = 9 + HUE_FRAC_BITS;
  // one 60 degree sector in hue units
  localparam int HUE_UNIT_BITS = 6 + HUE_FRAC_BITS;
  // sector-scaled numerator is below 6 * max channel code
  localparam int T_BITS        = CHANNEL_BITS + 3;
  // quotient bits shared by both dividers
  localparam int QUO_BITS      = (HUE_BITS > CHANNEL_BITS) ? HUE_BITS : CHANNEL_BITS;
  localparam int DIV_BITS      = QUO_BITS + CHANNEL_BITS;

  localparam logic [CHANNEL_BITS-1:0]  CH_MAX     = {CHANNEL_BITS{1'b1}};
  localparam logic [CHANNEL_BITS-1:0]  CH_ONE     = CHANNEL_BITS'(1);
  localparam logic [HUE_UNIT_BITS-1:0] HUE_UNIT   = HUE_UNIT_BITS'(60 << HUE_FRAC_BITS);
  localparam logic [HUE_BITS-1:0]      HUE_LIMIT  = HUE_BITS'(360 << HUE_FRAC_BITS);

  typedef logic [CHANNEL_BITS-1:0] chan_t;

  // one restoring divider lane: partial remainder, divisor, and a shift
  // register holding the unused dividend bits with quotient bits behind them
  typedef struct packed {
    chan_t               rem;
    chan_t               dvs;
    logic [QUO_BITS-1:0] acc;
  } div_lane_t;

  typedef struct packed {
    div_lane_t hue;
    div_lane_t sat;
    chan_t     bright;
  } div_word_t;

  typedef struct packed {
    logic [HUE_BITS-1:0] hue;
    chan_t               sat;
    chan_t               bright;
  } result_t;

endpackage

// ===== hdl/rgb_to_hsv_converter_core.sv =====
// ----------------------------------------------------------------------------
// rgb_to_hsv_converter_core: pipelined rgb to hsv colour conversion
// value is the largest channel, saturation and hue come from two restoring
// dividers that run side by side, one quotient bit per stage
// ----------------------------------------------------------------------------
//
//   channel   direction  handshake                   payload
//   pixel     in         pixel_valid / pixel_ready   red, green, blue
//   result    out        result_valid / result_ready hue, saturation, brightness
//
// one word per clock is taken while the result side keeps up
// a result passes the min/max stage, the scaling stage and one divider stage
// per quotient bit on its way from its pixel
// synchronous reset clears every valid bit, the skid valid bit among them; data
// registers keep whatever they held
// a stalled result moves into the skid register and the pipeline freezes
// while it is full, so pixel_ready is a register output
//
module rgb_to_hsv_converter_core
  import rhc_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                pixel_valid,
  output logic                pixel_ready,
  input  chan_t               red,
  input  chan_t               green,
  input  chan_t               blue,
  output logic                result_valid,
  input  logic                result_ready,
  output logic [HUE_BITS-1:0] hue,
  output chan_t               saturation,
  output chan_t               brightness
);

  // whole pipeline shifts together whenever the skid register is empty
  logic adv;

  // valid bits and words between divider stages
  logic [QUO_BITS:0] dv;
  div_word_t         dw [QUO_BITS+1];

  assign pixel_ready = adv;

  // max, min, sector numerator, then scaled dividends
  rhc_prep u_prep (
    .clk       (clk),
    .rst       (rst),
    .en        (adv),
    .in_valid  (pixel_valid),
    .red       (red),
    .green     (green),
    .blue      (blue),
    .out_valid (dv[0]),
    .out_word  (dw[0])
  );

  // divider chain, msb of the quotient first
  for (genvar i = 0; i < QUO_BITS; i++) begin : g_div
    rhc_div_stage u_stage (
      .clk       (clk),
      .rst       (rst),
      .en        (adv),
      .in_valid  (dv[i]),
      .in_word   (dw[i]),
      .out_valid (dv[i+1]),
      .out_word  (dw[i+1])
    );
  end

  // last stage doubles as the output register, backed by one skid word
  rhc_out_skid u_skid (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (dv[QUO_BITS]),
    .in_word    (dw[QUO_BITS]),
    .adv        (adv),
    .out_valid  (result_valid),
    .out_ready  (result_ready),
    .hue        (hue),
    .saturation (saturation),
    .brightness (brightness)
  );

`ifndef ASSERT_OFF
  // a black pixel has neither saturation nor hue
  a_black_is_grey: assert property (@(posedge clk) disable iff (rst)
    result_valid && (brightness == '0) |-> (saturation == '0) && (hue == '0))
    else $error("black pixel with nonzero saturation or hue");

  // hue stays inside one turn
  a_hue_range: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (hue < HUE_LIMIT))
    else $error("hue at or beyond 360 degrees");

  // zero saturation only happens for grey, whose hue is zero
  a_grey_hue: assert property (@(posedge clk) disable iff (rst)
    result_valid && (saturation == '0) |-> (hue == '0))
    else $error("zero saturation with nonzero hue");

  // the pipeline only freezes after a result was refused
  a_freeze_cause: assert property (@(posedge clk) disable iff (rst)
    $fell(pixel_ready) |-> $past(result_valid && !result_ready))
    else $error("pipeline froze without a stalled result");
`endif

endmodule

// ===== hdl/rhc_prep.sv =====
// ----------------------------------------------------------------------------
// rhc_prep: front of the converter pipeline
// stage one finds max, min and the sector numerator, stage two scales the
// numerators and loads both divider lanes
// ----------------------------------------------------------------------------
module rhc_prep
  import rhc_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      en,
  input  logic      in_valid,
  input  chan_t     red,
  input  chan_t     green,
  input  chan_t     blue,
  output logic      out_valid,
  output div_word_t out_word
);

  logic              a_valid;
  chan_t             a_hi;
  chan_t             a_diff;
  logic [T_BITS-1:0] a_t;

  chan_t             hi;
  chan_t             lo;
  chan_t             diff;
  logic [T_BITS-1:0] t_next;
  logic [T_BITS-1:0] r_ext;
  logic [T_BITS-1:0] g_ext;
  logic [T_BITS-1:0] b_ext;
  logic [T_BITS-1:0] d_ext;

  logic [DIV_BITS-1:0] num_hue;
  logic [DIV_BITS-1:0] num_sat;
  div_word_t           word_next;

  always_comb begin
    hi = red;
    lo = red;
    if (green > hi) hi = green;
    if (blue > hi)  hi = blue;
    if (green < lo) lo = green;
    if (blue < lo)  lo = blue;
    diff  = hi - lo;
    r_ext = T_BITS'(red);
    g_ext = T_BITS'(green);
    b_ext = T_BITS'(blue);
    d_ext = T_BITS'(diff);
    // ties go to red, then green
    priority if (diff == '0) begin
      t_next = '0;
    end else if (hi == red) begin
      if (green >= blue) begin
        t_next = g_ext - b_ext;
      end else begin
        t_next = (d_ext << 2) + (d_ext << 1) - (b_ext - g_ext);
      end
    end else if (hi == green) begin
      t_next = (d_ext << 1) + b_ext - r_ext;
    end else begin
      t_next = (d_ext << 2) + r_ext - g_ext;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (en) begin
      a_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_hi   <= hi;
      a_diff <= diff;
      a_t    <= t_next;
    end
  end

  always_comb begin
    num_hue = DIV_BITS'(a_t) * DIV_BITS'(HUE_UNIT);
    num_sat = DIV_BITS'(a_diff) * DIV_BITS'(CH_MAX);
    // zero divisors only meet zero numerators and become one, so the quotient is zero
    word_next.hue.rem = num_hue[DIV_BITS-1:QUO_BITS];
    word_next.hue.acc = num_hue[QUO_BITS-1:0];
    word_next.hue.dvs = (a_diff == '0) ? CH_ONE : a_diff;
    word_next.sat.rem = num_sat[DIV_BITS-1:QUO_BITS];
    word_next.sat.acc = num_sat[QUO_BITS-1:0];
    word_next.sat.dvs = (a_hi == '0) ? CH_ONE : a_hi;
    word_next.bright  = a_hi;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_word <= word_next;
    end
  end

endmodule

// ===== hdl/rhc_div_stage.sv =====
// ----------------------------------------------------------------------------
// rhc_div_stage: one restoring division step for both lanes
// each stage settles one quotient bit of hue and of saturation
// ----------------------------------------------------------------------------
module rhc_div_stage
  import rhc_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      en,
  input  logic      in_valid,
  input  div_word_t in_word,
  output logic      out_valid,
  output div_word_t out_word
);

  function automatic div_lane_t lane_step(input div_lane_t lane);
    logic [CHANNEL_BITS:0] shifted;
    logic [CHANNEL_BITS:0] dvs_ext;
    logic                  ge;
    div_lane_t             res;
    shifted = {lane.rem, lane.acc[QUO_BITS-1]};
    dvs_ext = {1'b0, lane.dvs};
    ge      = (shifted >= dvs_ext);
    res.dvs = lane.dvs;
    res.rem = ge ? CHANNEL_BITS'(shifted - dvs_ext) : shifted[CHANNEL_BITS-1:0];
    res.acc = {lane.acc[QUO_BITS-2:0], ge};
    return res;
  endfunction

  div_word_t word_next;

  always_comb begin
    word_next.hue    = lane_step(in_word.hue);
    word_next.sat    = lane_step(in_word.sat);
    word_next.bright = in_word.bright;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_word <= word_next;
    end
  end

endmodule

// ===== hdl/rhc_out_skid.sv =====
// ----------------------------------------------------------------------------
// rhc_out_skid: result skid register
// catches the last pipeline word when the consumer stalls, freezing the
// pipeline until it drains
// ----------------------------------------------------------------------------
module rhc_out_skid
  import rhc_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  div_word_t           in_word,
  output logic                adv,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [HUE_BITS-1:0] hue,
  output chan_t               saturation,
  output chan_t               brightness
);

  logic    skid_valid;
  result_t skid;
  result_t last;
  result_t shown;

  always_comb begin
    last.hue    = in_word.hue.acc[HUE_BITS-1:0];
    last.sat    = in_word.sat.acc[CHANNEL_BITS-1:0];
    last.bright = in_word.bright;
  end

  assign adv       = !skid_valid;
  assign out_valid = skid_valid || in_valid;
  assign shown     = skid_valid ? skid : last;

  assign hue        = shown.hue;
  assign saturation = shown.sat;
  assign brightness = shown.bright;

  always_ff @(posedge clk) begin
    if (rst) begin
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (out_ready) skid_valid <= 1'b0;
    end else if (in_valid && !out_ready) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!skid_valid) begin
      skid <= last;
    end
  end

endmodule
